// File: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants, CORDIC angle table and types for the
// great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Datapath widths
    localparam int ANG_W      = 30;   // angle entering the reduction, 2^-21 degree
    localparam int XY_W       = 34;   // CORDIC x/y, Q30
    localparam int Z_W        = 54;   // CORDIC angle, radians Q50
    localparam int ROOT_W     = 31;   // square root result, Q30
    localparam int RAD_W      = 62;   // square root remainder and trial
    localparam int SQRT_STEPS = 31;   // one result bit per step
    localparam int PREP_LAT   = 5;    // stages in the angle reduction
    localparam int PROD_W     = 2 * XY_W;
    localparam int NUM_W      = 61;   // scaled angle before the final divide

    // Fixed-point constants
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

    localparam logic signed [31:0] TURN_H  = 32'sd754974720;
    localparam logic signed [31:0] HALF_H  = 32'sd377487360;
    localparam logic signed [31:0] QUART_H = 32'sd188743680;

    // Degrees to radians: r * floor(pi*2^29) / 180, split as K = 180*KQ + KR
    localparam logic [30:0] RAD_K  = 31'(PI_Q60 >> 31);
    localparam logic [23:0] RAD_KQ = 24'(RAD_K / 31'd180);
    localparam logic [3:0]  RAD_KR = 4'(RAD_K % 31'd180);

    // floor(x/180): 28-bit x by a 2^-36 reciprocal, small x by a 2^-19 one
    localparam logic [28:0] DIV180_RECIP = 29'(((64'd1 << 36) + 64'd179) / 64'd180);
    localparam logic [11:0] DIV180_SMALL = 12'd2913;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // Radians Q50 to 2^-20 degree: z*360 / floor(pi*2^30), rounded half up
    localparam logic [31:0] SEP_DEN   = 32'(PI_Q60 >> 30);
    localparam logic [31:0] SEP_HALF  = SEP_DEN >> 1;
    localparam logic [28:0] SEP_RECIP = 29'(ONE_Q60 / {32'd0, SEP_DEN});
    localparam logic [27:0] SEP_MAX   = 28'd188743680;

    // Reduced angle handed to a rotation chain
    typedef struct packed {
        logic signed [Z_W-1:0] z;     // radians Q50
        logic                  neg;   // cosine changes sign after the fold
    } angle_t;

    // Square root partial state
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rem;
    } sqrt_t;

    // Series term divided by its odd denominator 2k+1
    function automatic logic [63:0] odd_div(input logic [63:0] v, input int k);
        case (k)
            0:  return v;
            1:  return v / 3;
            2:  return v / 5;
            3:  return v / 7;
            4:  return v / 9;
            5:  return v / 11;
            6:  return v / 13;
            7:  return v / 15;
            8:  return v / 17;
            9:  return v / 19;
            10: return v / 21;
            11: return v / 23;
            12: return v / 25;
            13: return v / 27;
            14: return v / 29;
            15: return v / 31;
            16: return v / 33;
            17: return v / 35;
            18: return v / 37;
            19: return v / 39;
            20: return v / 41;
            21: return v / 43;
            22: return v / 45;
            23: return v / 47;
            24: return v / 49;
            25: return v / 51;
            26: return v / 53;
            27: return v / 55;
            28: return v / 57;
            29: return v / 59;
            default: return v;
        endcase
    endfunction

    // atan(2^-i) in radians Q50, from a Q60 arctangent series
    function automatic logic signed [Z_W-1:0] atan_q50(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          sh;
        acc = 64'd0;
        if (i == 0)
        begin
            acc = PI_Q60 >> 2;
        end
        else
        begin
            for (int k = 0; k < 30; k++)
            begin
                sh = i * (2 * k + 1);
                if (sh <= 60)
                begin
                    term = odd_div(ONE_Q60 >> sh, k);
                    if (k[0])
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
            end
        end
        return Z_W'((acc + 64'd512) >> 10);
    endfunction

endpackage

// File: rtl/gcd_angle_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_angle_prep
// Wraps an angle into [-180,180), folds it into [-90,90] and converts it to
// radians Q50 in five pipeline stages.
// ----------------------------------------------------------------------------
module gcd_angle_prep
    import gcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output angle_t                  result
);

    logic signed [31:0] ang_ext;
    logic signed [31:0] wrap;
    logic signed [31:0] fold;
    logic signed [31:0] fold_abs;
    logic               fold_neg;

    logic [27:0] mag1_reg, mag1_next;
    logic        sgn1_reg, neg1_reg;

    logic [56:0] prod2_reg, prod2_next;
    logic [27:0] mag2_reg;
    logic        sgn2_reg, neg2_reg;

    logic [20:0] quo3_reg, quo3_next;
    logic [7:0]  rem3_reg, rem3_next;
    logic        sgn3_reg, neg3_reg;

    logic [51:0] qk4_reg, qk4_next;
    logic [31:0] rk4_reg, rk4_next;
    logic [11:0] r13_4_reg, r13_4_next;
    logic        sgn4_reg, neg4_reg;

    logic [23:0]           small_prod;
    logic [4:0]            frac;
    logic signed [Z_W-1:0] zmag;
    angle_t                res_reg, res_next;

    // Wrap and fold
    always_comb
    begin
        ang_ext  = {{(32 - ANG_W){angle[ANG_W-1]}}, angle};
        wrap     = ang_ext;
        if (ang_ext >= HALF_H)
            wrap = ang_ext - TURN_H;
        else if (ang_ext < -HALF_H)
            wrap = ang_ext + TURN_H;
        fold     = wrap;
        fold_neg = 1'b0;
        if (wrap > QUART_H)
        begin
            fold     = HALF_H - wrap;
            fold_neg = 1'b1;
        end
        else if (wrap < -QUART_H)
        begin
            fold     = -HALF_H - wrap;
            fold_neg = 1'b1;
        end
        fold_abs  = fold[31] ? -fold : fold;
        mag1_next = fold_abs[27:0];
    end

    // Quotient estimate of mag / 180
    assign prod2_next = 57'(mag1_reg) * 57'(DIV180_RECIP);

    // Quotient and remainder
    always_comb
    begin
        quo3_next = prod2_reg[56:36];
        rem3_next = 8'(mag2_reg - 28'(quo3_next) * 28'd180);
    end

    // Partial products of mag * K / 180
    always_comb
    begin
        qk4_next   = 52'(quo3_reg) * 52'(RAD_K);
        rk4_next   = 32'(rem3_reg) * 32'(RAD_KQ);
        r13_4_next = 12'(rem3_reg) * 12'(RAD_KR);
    end

    // Sum and restore sign, truncated toward zero
    always_comb
    begin
        small_prod   = 24'(r13_4_reg) * 24'(DIV180_SMALL);
        frac         = 5'(small_prod >> 19);
        zmag         = Z_W'(qk4_reg) + Z_W'(rk4_reg) + Z_W'(frac);
        res_next.z   = sgn4_reg ? -zmag : zmag;
        res_next.neg = neg4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg  <= mag1_next;
            sgn1_reg  <= fold[31];
            neg1_reg  <= fold_neg;
            prod2_reg <= prod2_next;
            mag2_reg  <= mag1_reg;
            sgn2_reg  <= sgn1_reg;
            neg2_reg  <= neg1_reg;
            quo3_reg  <= quo3_next;
            rem3_reg  <= rem3_next;
            sgn3_reg  <= sgn2_reg;
            neg3_reg  <= neg2_reg;
            qk4_reg   <= qk4_next;
            rk4_reg   <= rk4_next;
            r13_4_reg <= r13_4_next;
            sgn4_reg  <= sgn3_reg;
            neg4_reg  <= neg3_reg;
            res_reg   <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// File: rtl/gcd_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_cordic_cell
// One registered CORDIC iteration, in rotation mode (steer by z) or
// vectoring mode (steer by y).
// ----------------------------------------------------------------------------
module gcd_cordic_cell
    import gcd_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out
);

    localparam logic signed [Z_W-1:0] ANGLE = atan_q50(STAGE);

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   up;
    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;

    // Shift-add micro-rotation
    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        up = VECTOR ? y_in[XY_W-1] : !z_in[Z_W-1];
        if (up)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANGLE;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: rtl/gcd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// One registered digit of a restoring integer square root: decides one
// result bit and keeps the remainder v - root^2.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell
    import gcd_pkg::*;
#(
    parameter int BIT = 30
)
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t step_in,
    output sqrt_t step_out
);

    logic [RAD_W-1:0] trial;
    sqrt_t            step_reg, step_next;

    // Try setting this bit: (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    always_comb
    begin
        trial     = (RAD_W'(step_in.root) << (BIT + 1)) + (RAD_W'(1) << (2 * BIT));
        step_next = step_in;
        if (step_in.rem >= trial)
        begin
            step_next.rem  = step_in.rem - trial;
            step_next.root = step_in.root | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            step_reg <= step_next;
    end

    assign step_out = step_reg;

endmodule

// File: rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine angular separation of two sky positions, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one position pair per clock and returns one separation per pair, in
// order. The pipe is one input stage, five stages of angle reduction, a rotation
// CORDIC chain of CORDIC_ITERATIONS cells for four angles side by side, four
// multiply stages forming the haversine term, a 31-cell square root chain for
// sqrt(a) and sqrt(1-a), a vectoring CORDIC chain, and four stages of scaling
// to 2^-20 degree. The whole pipe stalls only while a result is held unaccepted.
// ----------------------------------------------------------------------------
module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ra_first[28:0], dec_first[56:29], ra_second[85:57], dec_second[113:86]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // separation[27:0]
    output logic [31:0]  m_tdata
);

    localparam int N   = CORDIC_ITERATIONS;
    localparam int LAT = 1 + PREP_LAT + N + 4 + SQRT_STEPS + N + 4;
    localparam logic signed [PROD_W-1:0] ONE_WIDE = PROD_W'(ONE_Q60);

    logic adv;
    logic [LAT-1:0] valid_reg;

    logic [28:0]             ra_first, ra_second;
    logic [27:0]             dec_first, dec_second;
    logic signed [ANG_W-1:0] ang_reg [4];
    logic signed [ANG_W-1:0] ang_next [4];
    angle_t                  prep_out [4];

    logic signed [XY_W-1:0] rot_x [4][N+1];
    logic signed [XY_W-1:0] rot_y [4][N+1];
    logic signed [Z_W-1:0]  rot_z [4][N+1];
    logic [1:0]             cneg_reg [N];

    logic signed [XY_W-1:0]   cos1, cos2;
    logic signed [PROD_W-1:0] c12_prod, t_prod;
    logic signed [XY_W-1:0]   c12_reg, sd1_reg, sr1_reg;
    logic signed [XY_W-1:0]   t_reg, sd2_reg, sr2_reg;
    logic signed [PROD_W-1:0] pd_reg, pr_reg;
    logic signed [PROD_W-1:0] a_sum;
    logic [60:0]              a_clamp;

    sqrt_t sq [2][SQRT_STEPS+1];
    sqrt_t sq0_next, sq1_next;
    sqrt_t sq0_reg, sq1_reg;

    logic signed [XY_W-1:0] vec_x [N+1];
    logic signed [XY_W-1:0] vec_y [N+1];
    logic signed [Z_W-1:0]  vec_z [N+1];

    logic [NUM_W-1:0] num_reg, num_next;
    logic [61:0]      pm_reg, pm_next;
    logic [35:0]      numlo2_reg, numlo3_reg;
    logic [28:0]      qe_reg, qe_next;
    logic [35:0]      qd_reg, qd_next;
    logic [35:0]      rem;
    logic [28:0]      quo;
    logic [27:0]      sep_reg, sep_next;

    // Advance the whole pipe unless the held result is refused
    assign adv      = !valid_reg[LAT-1] || m_tready;
    assign s_tready = adv && rst_n;
    assign m_tvalid = valid_reg[LAT-1];
    assign m_tdata  = {4'd0, sep_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
    end

    // Unpack and form the four trig angles in 2^-21 degree
    always_comb
    begin
        ra_first    = s_tdata[28:0];
        dec_first   = s_tdata[56:29];
        ra_second   = s_tdata[85:57];
        dec_second  = s_tdata[113:86];
        ang_next[0] = {{2{dec_second[27]}}, dec_second} - {{2{dec_first[27]}}, dec_first};
        ang_next[1] = {1'b0, ra_second} - {1'b0, ra_first};
        ang_next[2] = {dec_first[27], dec_first, 1'b0};
        ang_next[3] = {dec_second[27], dec_second, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ang_reg <= ang_next;
    end

    // Reduction and rotation chains, one lane per angle
    genvar l, s;
    generate
        for (l = 0; l < 4; l++)
        begin : g_rot_lane
            gcd_angle_prep u_prep
            (
                .clk    (clk),
                .en     (adv),
                .angle  (ang_reg[l]),
                .result (prep_out[l])
            );

            assign rot_x[l][0] = CORDIC_GAIN;
            assign rot_y[l][0] = '0;
            assign rot_z[l][0] = prep_out[l].z;

            for (s = 0; s < N; s++)
            begin : g_rot_cell
                gcd_cordic_cell #(.STAGE(s), .VECTOR(1'b0)) u_cell
                (
                    .clk   (clk),
                    .en    (adv),
                    .x_in  (rot_x[l][s]),
                    .y_in  (rot_y[l][s]),
                    .z_in  (rot_z[l][s]),
                    .x_out (rot_x[l][s+1]),
                    .y_out (rot_y[l][s+1]),
                    .z_out (rot_z[l][s+1])
                );
            end
        end
    endgenerate

    // Carry the cosine sign flips of both declinations along the chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cneg_reg[0] <= {prep_out[3].neg, prep_out[2].neg};
            for (int i = 1; i < N; i++)
                cneg_reg[i] <= cneg_reg[i-1];
        end
    end

    // Haversine term: a = sD^2 + ((cos1*cos2)*sR)*sR
    always_comb
    begin
        cos1     = cneg_reg[N-1][0] ? -rot_x[2][N] : rot_x[2][N];
        cos2     = cneg_reg[N-1][1] ? -rot_x[3][N] : rot_x[3][N];
        c12_prod = PROD_W'(cos1) * PROD_W'(cos2);
        t_prod   = PROD_W'(c12_reg) * PROD_W'(sr1_reg);
        a_sum    = pd_reg + pr_reg;
        if (a_sum[PROD_W-1])
            a_clamp = '0;
        else if (a_sum > ONE_WIDE)
            a_clamp = ONE_Q60[60:0];
        else
            a_clamp = a_sum[60:0];
        sq0_next.root = '0;
        sq0_next.rem  = RAD_W'(a_clamp);
        sq1_next.root = '0;
        sq1_next.rem  = RAD_W'(ONE_Q60[60:0] - a_clamp);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c12_reg <= XY_W'(c12_prod >>> 30);
            sd1_reg <= rot_y[0][N];
            sr1_reg <= rot_y[1][N];
            t_reg   <= XY_W'(t_prod >>> 30);
            sd2_reg <= sd1_reg;
            sr2_reg <= sr1_reg;
            pd_reg  <= PROD_W'(sd2_reg) * PROD_W'(sd2_reg);
            pr_reg  <= PROD_W'(t_reg) * PROD_W'(sr2_reg);
            sq0_reg <= sq0_next;
            sq1_reg <= sq1_next;
        end
    end

    // Square roots of a and 1 - a
    assign sq[0][0] = sq0_reg;
    assign sq[1][0] = sq1_reg;

    generate
        for (l = 0; l < 2; l++)
        begin : g_sqrt_lane
            for (s = 0; s < SQRT_STEPS; s++)
            begin : g_sqrt_cell
                gcd_sqrt_cell #(.BIT(SQRT_STEPS - 1 - s)) u_cell
                (
                    .clk      (clk),
                    .en       (adv),
                    .step_in  (sq[l][s]),
                    .step_out (sq[l][s+1])
                );
            end
        end
    endgenerate

    // atan2(sqrt a, sqrt(1-a)) by vectoring
    assign vec_x[0] = XY_W'(sq[1][SQRT_STEPS].root);
    assign vec_y[0] = XY_W'(sq[0][SQRT_STEPS].root);
    assign vec_z[0] = '0;

    generate
        for (s = 0; s < N; s++)
        begin : g_vec_cell
            gcd_cordic_cell #(.STAGE(s), .VECTOR(1'b1)) u_cell
            (
                .clk   (clk),
                .en    (adv),
                .x_in  (vec_x[s]),
                .y_in  (vec_y[s]),
                .z_in  (vec_z[s]),
                .x_out (vec_x[s+1]),
                .y_out (vec_y[s+1]),
                .z_out (vec_z[s+1])
            );
        end
    endgenerate

    // Scale to 2^-20 degree: round(2z*180 / (pi*2^30)), quotient by reciprocal
    always_comb
    begin
        if (vec_z[N][Z_W-1])
            num_next = '0;
        else
            num_next = NUM_W'(vec_z[N]) * NUM_W'(360) + NUM_W'(SEP_HALF);
        pm_next = 62'(num_reg[NUM_W-1:28]) * 62'(SEP_RECIP);
        qe_next = pm_reg[60:32];
        qd_next = 36'(61'(qe_next) * 61'(SEP_DEN));
        rem     = numlo3_reg - qd_reg;
        if (rem >= 36'({SEP_DEN, 1'b0}))
            quo = qe_reg + 29'd2;
        else if (rem >= 36'(SEP_DEN))
            quo = qe_reg + 29'd1;
        else
            quo = qe_reg;
        if (quo > 29'(SEP_MAX))
            sep_next = SEP_MAX;
        else
            sep_next = quo[27:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg    <= num_next;
            pm_reg     <= pm_next;
            numlo2_reg <= num_reg[35:0];
            qe_reg     <= qe_next;
            qd_reg     <= qd_next;
            numlo3_reg <= numlo2_reg;
            sep_reg    <= sep_next;
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pipelined haversine separation: directed and random position pairs.
// ----------------------------------------------------------------------------
// A queue of position pairs feeds a streaming driver. Each accepted request
// is run through a fixed-point haversine predictor (rotation CORDIC, bitwise
// square roots, vectoring CORDIC). The predicted separation is queued, and
// the monitor compares each delivered result with the oldest one in order.
// ----------------------------------------------------------------------------
module tb_top;
    import gcd_pkg::*;

    localparam int ITERS     = 24;
    localparam int LATENCY   = 2 * ITERS + 45;
    localparam int WDOG_MAX  = 4000;
    localparam longint TURN  = 754974720;
    localparam longint HALF  = 377487360;
    localparam longint QUART = 188743680;
    localparam longint DEC_MAX = 94371840;
    localparam longint RA_MAX  = 377487359;

    typedef struct packed {
        logic signed [27:0] dec_second;
        logic        [28:0] ra_second;
        logic signed [27:0] dec_first;
        logic        [28:0] ra_first;
    } pair_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    pair_t        pending_pairs[$];
    logic [27:0]  expected_seps[$];
    longint       atan_rad[ITERS];
    int           error_count;
    int           idle_cycles;
    int           cycle_count;
    bit           no_idle;
    bit           hold_sink;
    int           hold_count;

    great_circle_distance #(.CORDIC_ITERATIONS(ITERS)) u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    // Build arctangent table in radians Q50 from a Q60 series
    function automatic void build_atan();
        longint unsigned acc;
        longint unsigned term;
        int sh;
        for (int i = 0; i < ITERS; i++)
        begin
            acc = 0;
            if (i == 0)
                acc = PI_Q60 >> 2;
            else
                for (int k = 0; k < 40; k++)
                begin
                    sh = i * (2 * k + 1);
                    if (sh <= 60)
                    begin
                        term = (ONE_Q60 >> sh) / (2 * k + 1);
                        if (k % 2 == 1)
                            acc = acc - term;
                        else
                            acc = acc + term;
                    end
                end
            atan_rad[i] = longint'((acc + 512) >> 10);
        end
    endfunction

    // Angle in 2^-21 degree to sine and cosine in Q30
    function automatic void rotate(longint v, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     neg;
        neg = 0;
        r = v % TURN;
        if (r >= HALF) r -= TURN;
        if (r < -HALF) r += TURN;
        if (r > QUART)
        begin
            r = HALF - r;
            neg = 1;
        end
        else if (r < -QUART)
        begin
            r = -HALF - r;
            neg = 1;
        end
        z = r * longint'(PI_Q60 >> 31) / 180;
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_rad[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_rad[i];
            end
        end
        s = y;
        c = neg ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned t;
        root = 0;
        for (int b = 30; b >= 0; b--)
        begin
            t = root | (64'd1 << b);
            if (t * t <= v)
                root = t;
        end
        return root;
    endfunction

    function automatic logic [27:0] predict_separation(pair_t p);
        longint sd, cd, sr, cr, s1, c1, s2, c2, c12, a, x, y, z, dx, dy;
        longint unsigned sep;
        longint unsigned den;
        rotate(longint'(p.dec_second) - longint'(p.dec_first), sd, cd);
        rotate(longint'(p.ra_second) - longint'(p.ra_first), sr, cr);
        rotate(2 * longint'(p.dec_first), s1, c1);
        rotate(2 * longint'(p.dec_second), s2, c2);
        c12 = shr(c1 * c2, 30);
        a = sd * sd + shr(c12 * sr, 30) * sr;
        if (a < 0) a = 0;
        if (a > longint'(ONE_Q60)) a = longint'(ONE_Q60);
        y = longint'(int_sqrt(a));
        x = longint'(int_sqrt(ONE_Q60 - a));
        z = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_rad[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_rad[i];
            end
        end
        if (z < 0) z = 0;
        den = PI_Q60 >> 30;
        sep = (longint'(z) * 360 + den / 2) / den;
        if (sep > 188743680) sep = 188743680;
        return sep[27:0];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic pair_t make_pair(longint ra1, longint d1, longint ra2, longint d2);
        pair_t p;
        p.ra_first   = ra1[28:0];
        p.dec_first  = d1[27:0];
        p.ra_second  = ra2[28:0];
        p.dec_second = d2[27:0];
        return p;
    endfunction

    function automatic longint rand_dec();
        return longint'($urandom_range(2 * DEC_MAX)) - DEC_MAX;
    endfunction

    function automatic pair_t rand_pair();
        int kind;
        longint ra1, d1;
        kind = $urandom_range(9);
        ra1 = $urandom_range(RA_MAX);
        d1  = rand_dec();
        case (kind)
            // neighbors in right ascension, second declination about half the first
            0, 1: return make_pair(ra1, d1,
                                   (ra1 + $urandom_range(2000)) % (RA_MAX + 1),
                                   d1 / 2 + longint'($urandom_range(2000)) - 1000);
            // near antipode
            2: return make_pair(ra1, d1, (ra1 + HALF / 2 + $urandom_range(64)) %
                                (RA_MAX + 1), -d1);
            // raw random bits, declinations beyond the pole included
            3: return make_pair($urandom_range(RA_MAX),
                                longint'($signed({$urandom} % (1 << 28)) <<< 4) >>> 4,
                                $urandom_range(RA_MAX),
                                longint'($signed({$urandom} % (1 << 28)) <<< 4) >>> 4);
            default: return make_pair(ra1, d1, $urandom_range(RA_MAX), rand_dec());
        endcase
    endfunction

    // Fill stimulus: directed corners, then random pairs
    initial
    begin
        pair_t p;
        build_atan();
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(RA_MAX, DEC_MAX, RA_MAX, DEC_MAX));
        pending_pairs.push_back(make_pair(0, 0, HALF / 2, 0));
        pending_pairs.push_back(make_pair(0, DEC_MAX, 0, -DEC_MAX));
        pending_pairs.push_back(make_pair(10, -DEC_MAX, 10, DEC_MAX));
        pending_pairs.push_back(make_pair(0, 1000, HALF / 2, -1000));
        pending_pairs.push_back(make_pair(RA_MAX, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, RA_MAX, 0));
        pending_pairs.push_back(make_pair(0, DEC_MAX, RA_MAX, DEC_MAX));
        pending_pairs.push_back(make_pair(0, 0, 1, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 1));
        pending_pairs.push_back(make_pair(123456, 7890, 123456, 7890));
        pending_pairs.push_back(make_pair(0, 134217727, 0, -134217728));
        pending_pairs.push_back(make_pair(536870911, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 536870911, 100000000));
        pending_pairs.push_back(make_pair(5000, -50000000, 200000000, 60000000));
        pending_pairs.push_back(make_pair(0, DEC_MAX / 2, HALF / 4, -DEC_MAX / 3));
        pending_pairs.push_back(make_pair(300000000, 1, 1, -1));
        for (int i = 0; i < 1430; i++)
        begin
            p = rand_pair();
            pending_pairs.push_back(p);
        end
    end

    // Reset and end-of-run control
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !s_tvalid);
        wait (expected_seps.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_seps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Source: offer pairs, idle at random; one drain pause midway
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_seps.push_back(predict_separation(pair_t'(s_tdata[113:0])));
            if (pending_pairs.size() == 700 && expected_seps.size() != 0)
                s_tvalid <= 1'b0;
            else if (pending_pairs.size() != 0 && (no_idle || $urandom_range(99) >= 18))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, pending_pairs.pop_front()};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Stretch with no idling on either side
    always_comb no_idle = (pending_pairs.size() > 300 && pending_pairs.size() < 500);

    // Sink: random stalls, one long hold while the source keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_sink  <= 1'b1;
            hold_count <= 0;
        end
        else
        begin
            if (hold_sink && pending_pairs.size() < 1200)
            begin
                hold_count <= hold_count + 1;
                if (hold_count >= 300)
                    hold_sink <= 1'b0;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || $urandom_range(99) >= 18;
        end
    end

    // Check results and run the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink &&
                hold_count > 0 && hold_count < 300)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_seps.size() == 0)
                    report_mismatch("unexpected separation", m_tdata[27:0], -1);
                else
                begin
                    if (m_tdata[27:0] !== expected_seps[0])
                        report_mismatch("separation", m_tdata[27:0], expected_seps[0]);
                    if (m_tdata[31:28] !== 4'd0)
                        report_mismatch("pad bits", m_tdata[31:28], 0);
                    void'(expected_seps.pop_front());
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        cycle_count = 0;
    end

endmodule

// File: filelist.f
rtl/gcd_pkg.sv
rtl/gcd_angle_prep.sv
rtl/gcd_cordic_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/great_circle_distance.sv
dv/tb_top.sv
